/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is asserted.
`define HMF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the same check.
`define HMF_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
	`HMF_ASSERT(label, clk, rst_n, (pre) |-> (post), msg)

`endif

/* sv/hmf_pkg.sv */
// Package with the types, codes and character tables of the HTTP/1 message framer.
`default_nettype none
package hmf_pkg;

	typedef enum logic [2:0] {
		PH_HDR  = 3'd0,
		PH_CLV  = 3'd1,
		PH_TEV  = 3'd2,
		PH_SIZE = 3'd3,
		PH_EXT  = 3'd4,
		PH_DATA = 3'd5,
		PH_TRL  = 3'd6,
		PH_BODY = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		RL_START   = 3'd0,
		RL_METHOD  = 3'd1,
		RL_SLASH   = 3'd2,
		RL_TARGET  = 3'd3,
		RL_VERSION = 3'd4,
		RL_OK      = 3'd5,
		RL_BAD     = 3'd6
	} rl_t;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_CTRL     = 3'd1;
	localparam logic [2:0] ERR_BARE_CR  = 3'd2;
	localparam logic [2:0] ERR_REQ_LINE = 3'd3;
	localparam logic [2:0] ERR_LIMIT    = 3'd4;
	localparam logic [2:0] ERR_HEX      = 3'd5;
	localparam logic [2:0] ERR_MAX_CODE = 3'd5;

	localparam logic [1:0] SEG_HEADER  = 2'd0;
	localparam logic [1:0] SEG_CHUNK   = 2'd1;
	localparam logic [1:0] SEG_TRAILER = 2'd2;
	localparam logic [1:0] SEG_BODY    = 2'd3;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_C     = 8'h63;

	localparam logic [23:0] CRLFCR = 24'h0D0A0D;

	// Fields of the scanner state other than the lengths, all of fixed width.
	typedef struct packed {
		phase_t      phase;
		logic [23:0] recent;
		logic [4:0]  line_pos;
		logic [1:0]  name_flags;
		logic        chunked_seen;
		logic [2:0]  chunked_pos;
		logic [31:0] seg_count;
		rl_t         rl_state;
		logic [2:0]  sticky_err;
	} hmf_state_t;

	// One result of the framer.
	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] segment;
		logic       segment_last;
		logic [2:0] error_code;
	} hmf_result_t;

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		to_lower = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
	endfunction

	function automatic logic is_ctrl(input logic [7:0] b);
		is_ctrl = (b == CH_DEL) ||
			(b < 8'h20 && b != CH_TAB && b != CH_LF && b != CH_CR);
	endfunction

	// Characters of "content-length:".
	function automatic logic [7:0] cl_char(input logic [4:0] pos);
		unique case (pos)
			5'd0: cl_char = "c";
			5'd1: cl_char = "o";
			5'd2: cl_char = "n";
			5'd3: cl_char = "t";
			5'd4: cl_char = "e";
			5'd5: cl_char = "n";
			5'd6: cl_char = "t";
			5'd7: cl_char = "-";
			5'd8: cl_char = "l";
			5'd9: cl_char = "e";
			5'd10: cl_char = "n";
			5'd11: cl_char = "g";
			5'd12: cl_char = "t";
			5'd13: cl_char = "h";
			5'd14: cl_char = ":";
			default: cl_char = 8'h00;
		endcase
	endfunction

	// Characters of "transfer-encoding:".
	function automatic logic [7:0] te_char(input logic [4:0] pos);
		unique case (pos)
			5'd0: te_char = "t";
			5'd1: te_char = "r";
			5'd2: te_char = "a";
			5'd3: te_char = "n";
			5'd4: te_char = "s";
			5'd5: te_char = "f";
			5'd6: te_char = "e";
			5'd7: te_char = "r";
			5'd8: te_char = "-";
			5'd9: te_char = "e";
			5'd10: te_char = "n";
			5'd11: te_char = "c";
			5'd12: te_char = "o";
			5'd13: te_char = "d";
			5'd14: te_char = "i";
			5'd15: te_char = "n";
			5'd16: te_char = "g";
			5'd17: te_char = ":";
			default: te_char = 8'h00;
		endcase
	endfunction

	// Characters of "chunked".
	function automatic logic [7:0] chunked_char(input logic [2:0] pos);
		unique case (pos)
			3'd0: chunked_char = "c";
			3'd1: chunked_char = "h";
			3'd2: chunked_char = "u";
			3'd3: chunked_char = "n";
			3'd4: chunked_char = "k";
			3'd5: chunked_char = "e";
			3'd6: chunked_char = "d";
			default: chunked_char = 8'h00;
		endcase
	endfunction

	// Characters of "HTTP/".
	function automatic logic [7:0] http_char(input logic [4:0] pos);
		unique case (pos)
			5'd0: http_char = "H";
			5'd1: http_char = "T";
			5'd2: http_char = "T";
			5'd3: http_char = "P";
			5'd4: http_char = "/";
			default: http_char = 8'h00;
		endcase
	endfunction

endpackage
`default_nettype wire

/* sv/hmf_in_if.sv */
// Input byte channel.
`default_nettype none
interface hmf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

/* sv/hmf_out_if.sv */
// Result channel: the byte with its segment tag and error code.
`default_nettype none
interface hmf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] segment;
	logic       segment_last;
	logic [2:0] error_code;
	modport source (output valid, output out_byte, output segment, output segment_last,
		output error_code, input ready);
	modport sink (input valid, input out_byte, input segment, input segment_last,
		input error_code, output ready);
endinterface
`default_nettype wire

/* sv/hmf_cfg_if.sv */
// Configuration write channel for the segment length limit.
`default_nettype none
interface hmf_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] max_segment_bytes;
	modport source (output valid, output max_segment_bytes, input ready);
	modport sink (input valid, input max_segment_bytes, output ready);
endinterface
`default_nettype wire

/* sv/hmf_next.sv */
// Next-state and result logic of the framer for one byte.
`default_nettype none
module hmf_next import hmf_pkg::*; #(
	parameter int LENGTH_BITS = 32
) (
	input  wire hmf_state_t             st,
	input  wire logic [LENGTH_BITS-1:0] body_len,
	input  wire logic [LENGTH_BITS-1:0] chunk_rem,
	input  wire logic [7:0]             b,
	input  wire logic [31:0]            max_seg,
	output hmf_state_t                  nst,
	output logic [LENGTH_BITS-1:0]      nbody_len,
	output logic [LENGTH_BITS-1:0]      nchunk_rem,
	output hmf_result_t                 res
);

	localparam int LB = LENGTH_BITS;
	localparam int WB = (LB > 32) ? LB : 32;
	localparam int TW = WB + 2;
	localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

	hmf_state_t          n;
	hmf_state_t          fresh;
	logic [LB-1:0]       nb;
	logic [LB-1:0]       nc;
	logic [LB-1:0]       dec;
	logic [LB+3:0]       wide;
	logic [TW-1:0]       total;
	logic [3:0]          digit;
	logic [7:0]          c;
	logic [2:0]          err;
	logic [1:0]          seg;
	logic                last;
	logic                prev_cr;
	logic                end3;
	logic                skip;
	logic                done;
	logic [1:0]          flags;
	logic                max_on;

	always_comb begin
		n = st;
		nb = body_len;
		nc = chunk_rem;
		seg = SEG_HEADER;
		last = 1'b0;
		err = ERR_NONE;
		skip = 1'b0;
		done = 1'b0;
		flags = st.name_flags;
		dec = '0;
		wide = '0;
		total = '0;
		digit = '0;
		c = to_lower(b);
		prev_cr = (st.recent[7:0] == CH_CR);
		end3 = (b == CH_LF) && (st.recent == CRLFCR);
		max_on = (max_seg != 32'd0);

		// State of a new message; the sticky error is kept.
		fresh = st;
		fresh.phase = PH_HDR;
		fresh.recent = '0;
		fresh.line_pos = '0;
		fresh.name_flags = '0;
		fresh.chunked_seen = 1'b0;
		fresh.chunked_pos = '0;
		fresh.seg_count = '0;
		fresh.rl_state = RL_START;

		if (st.sticky_err != ERR_NONE) begin
			err = st.sticky_err;
		end else if (max_on && st.seg_count >= max_seg) begin
			err = ERR_LIMIT;
		end else begin
			n.recent = {st.recent[15:0], b};
			if (st.seg_count != 32'hFFFF_FFFF) begin
				n.seg_count = st.seg_count + 32'd1;
			end
			unique case (st.phase)
				PH_HDR, PH_CLV, PH_TEV: begin
					if (prev_cr && b != CH_LF) begin
						err = ERR_BARE_CR;
					end else if (is_ctrl(b)) begin
						err = ERR_CTRL;
					end else if (end3) begin
						last = 1'b1;
						if (st.rl_state != RL_OK) begin
							err = ERR_REQ_LINE;
						end else if (st.chunked_seen) begin
							n = fresh;
							n.phase = PH_SIZE;
							nb = '0;
							nc = '0;
						end else if (body_len != '0) begin
							if (max_on && WB'(body_len) > WB'(max_seg)) begin
								err = ERR_LIMIT;
							end else begin
								n = fresh;
								n.phase = PH_BODY;
								nc = '0;
							end
						end else begin
							n = fresh;
							nb = '0;
							nc = '0;
						end
					end else begin
						// Value of a matched header, then the line scan.
						if (st.phase == PH_CLV) begin
							if (st.line_pos == 5'd15 && (b == CH_SP || b == CH_TAB)) begin
								skip = 1'b1;
							end else if (b >= "0" && b <= "9") begin
								digit = 4'(b - "0");
								wide = {body_len, 3'b000} + {2'b00, body_len, 1'b0}
									+ (LB+4)'(digit);
								nb = (wide[LB+3:LB] != 4'd0) ? LEN_MAX : wide[LB-1:0];
								n.line_pos = 5'd16;
								skip = 1'b1;
							end else begin
								n.phase = PH_HDR;
							end
						end else if (st.phase == PH_TEV) begin
							if (b != CH_CR) begin
								if (st.chunked_pos < 3'd7 && c == chunked_char(st.chunked_pos)) begin
									n.chunked_pos = st.chunked_pos + 3'd1;
								end else begin
									n.chunked_pos = (c == CH_C) ? 3'd1 : 3'd0;
								end
								if (n.chunked_pos == 3'd7) begin
									n.chunked_seen = 1'b1;
									n.chunked_pos = 3'd0;
									n.phase = PH_HDR;
								end
								skip = 1'b1;
							end else begin
								n.chunked_pos = 3'd0;
								n.phase = PH_HDR;
							end
						end
						if (!skip) begin
							if (st.rl_state < RL_OK) begin
								// Shape of the request line.
								if (b == CH_CR) begin
									n.rl_state = RL_BAD;
								end else begin
									unique case (st.rl_state)
										RL_START: n.rl_state = (b == CH_SP) ? RL_BAD : RL_METHOD;
										RL_METHOD: if (b == CH_SP) n.rl_state = RL_SLASH;
										RL_SLASH: n.rl_state = (b == CH_SLASH) ? RL_TARGET : RL_BAD;
										RL_TARGET: begin
											if (b == CH_SP) begin
												n.rl_state = RL_VERSION;
												n.line_pos = 5'd0;
											end
										end
										default: begin
											if (st.line_pos < 5'd5 && b == http_char(st.line_pos)) begin
												n.line_pos = st.line_pos + 5'd1;
												if (n.line_pos == 5'd5) n.rl_state = RL_OK;
											end else begin
												n.rl_state = RL_BAD;
											end
										end
									endcase
								end
							end else if (b == CH_LF && prev_cr) begin
								n.line_pos = 5'd0;
								n.name_flags = {~n.chunked_seen, body_len == '0};
							end else begin
								// Header name match at the line start.
								if (flags != 2'd0) begin
									if (flags[0] && !(st.line_pos < 5'd15 && c == cl_char(st.line_pos)))
										flags[0] = 1'b0;
									if (flags[1] && !(st.line_pos < 5'd18 && c == te_char(st.line_pos)))
										flags[1] = 1'b0;
									if (flags[0] && st.line_pos == 5'd14) begin
										flags = 2'd0;
										n.line_pos = 5'd15;
										n.phase = PH_CLV;
										done = 1'b1;
									end else if (flags[1] && st.line_pos == 5'd17) begin
										flags = 2'd0;
										n.chunked_pos = 3'd0;
										n.phase = PH_TEV;
										done = 1'b1;
									end
								end
								n.name_flags = flags;
								if (!done && st.line_pos < 5'd31) n.line_pos = st.line_pos + 5'd1;
							end
						end
					end
				end
				PH_SIZE, PH_EXT: begin
					if (prev_cr) begin
						if (b != CH_LF) err = ERR_BARE_CR;
						else done = 1'b1;
					end else if (b == CH_CR || st.phase == PH_EXT) begin
						done = 1'b0;
					end else if (b == CH_SEMI) begin
						n.phase = PH_EXT;
					end else begin
						if (c >= "0" && c <= "9") begin
							digit = 4'(c - "0");
						end else if (c >= "a" && c <= "f") begin
							digit = 4'(c - "a" + 8'd10);
						end else begin
							err = ERR_HEX;
						end
						wide = {chunk_rem, 4'b0000} + (LB+4)'(digit);
						if (err == ERR_NONE) begin
							nc = (chunk_rem[LB-1 -: 4] != 4'd0) ? LEN_MAX : wide[LB-1:0];
						end
					end
					seg = (nc != '0) ? SEG_CHUNK : SEG_TRAILER;
					if (done) begin
						if (nc == '0) begin
							n.phase = PH_TRL;
						end else begin
							// The segment count already includes this byte.
							total = TW'(n.seg_count) + TW'(nc) + TW'(2);
							if (total > TW'(LEN_MAX)) total = TW'(LEN_MAX);
							if (max_on && total > TW'(max_seg)) begin
								err = ERR_LIMIT;
							end else begin
								nc = (nc > LEN_MAX - LB'(2)) ? LEN_MAX : nc + LB'(2);
								n.phase = PH_DATA;
							end
						end
					end
				end
				PH_DATA: begin
					seg = SEG_CHUNK;
					dec = (chunk_rem != '0) ? chunk_rem - LB'(1) : '0;
					nc = dec;
					if (dec == '0) begin
						last = 1'b1;
						n.phase = PH_SIZE;
						n.seg_count = '0;
						n.recent = '0;
					end
				end
				PH_TRL: begin
					if (prev_cr && b != CH_LF) begin
						err = ERR_BARE_CR;
					end else if (is_ctrl(b)) begin
						err = ERR_CTRL;
					end else begin
						seg = SEG_TRAILER;
						if (end3) begin
							last = 1'b1;
							n = fresh;
							nb = '0;
							nc = '0;
						end
					end
				end
				default: begin
					seg = SEG_BODY;
					dec = (body_len != '0) ? body_len - LB'(1) : '0;
					nb = dec;
					if (dec == '0) begin
						last = 1'b1;
						n = fresh;
						nc = '0;
					end
				end
			endcase
		end

		// An error freezes the scan and blanks the payload.
		if (err != ERR_NONE) begin
			nst = st;
			nst.sticky_err = err;
			nbody_len = body_len;
			nchunk_rem = chunk_rem;
			res = '{out_byte: 8'h00, segment: SEG_HEADER, segment_last: 1'b0, error_code: err};
		end else begin
			nst = n;
			nbody_len = nb;
			nchunk_rem = nc;
			res = '{out_byte: b, segment: seg, segment_last: last, error_code: ERR_NONE};
		end
	end

endmodule
`default_nettype wire

/* sv/http1_message_framer_core.sv */
// Top level of the HTTP/1 request stream framer.
// Usage:
// Bytes of the request stream enter on in_ch, one per transaction. Every
// accepted byte yields exactly one result on out_ch: the byte, its segment
// (header, chunk, zero chunk with trailers, or length body), a flag on the
// last byte of the segment, and an error code. After an error, every later
// result carries the same code with a zero payload until reset.
// The length limit is written on cfg_ch, which is always ready; write it only
// while no result is outstanding. Zero disables the limit.
// The result is registered at the edge that accepts the byte. Throughput is
// one byte per cycle while the receiver does not stall; the whole scanner
// state updates in a single pass through the next-state logic.
// When the receiver stalls, the result stays in the output register and in_ch
// still takes a byte in any cycle in which that register empties.
// Reset clears the scanner to the start of a header block, the limit to zero
// and drops any pending result.
`default_nettype none
module http1_message_framer_core import hmf_pkg::*; #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hmf_in_if.sink    in_ch,
	hmf_out_if.source out_ch,
	hmf_cfg_if.sink   cfg_ch
);

	hmf_state_t             state_q;
	hmf_state_t             state_nxt;
	logic [LENGTH_BITS-1:0] body_len_q;
	logic [LENGTH_BITS-1:0] body_len_nxt;
	logic [LENGTH_BITS-1:0] chunk_rem_q;
	logic [LENGTH_BITS-1:0] chunk_rem_nxt;
	logic [31:0]            max_seg_q;
	hmf_result_t            res_nxt;
	hmf_result_t            res_q;
	logic                   out_valid_q;
	logic                   in_take;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_take = in_ch.valid && in_ch.ready;

	hmf_next #(.LENGTH_BITS(LENGTH_BITS)) u_next (
		.st         (state_q),
		.body_len   (body_len_q),
		.chunk_rem  (chunk_rem_q),
		.b          (in_ch.in_byte),
		.max_seg    (max_seg_q),
		.nst        (state_nxt),
		.nbody_len  (body_len_nxt),
		.nchunk_rem (chunk_rem_nxt),
		.res        (res_nxt)
	);

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seg_q <= '0;
		end else if (cfg_ch.valid) begin
			max_seg_q <= cfg_ch.max_segment_bytes;
		end
	end

	// Scanner state, updated once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_HDR, recent: '0, line_pos: '0, name_flags: '0,
				chunked_seen: 1'b0, chunked_pos: '0, seg_count: '0, rl_state: RL_START,
				sticky_err: ERR_NONE};
			body_len_q <= '0;
			chunk_rem_q <= '0;
		end else if (in_take) begin
			state_q <= state_nxt;
			body_len_q <= body_len_nxt;
			chunk_rem_q <= chunk_rem_nxt;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			res_q <= res_nxt;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = res_q.out_byte;
	assign out_ch.segment = res_q.segment;
	assign out_ch.segment_last = res_q.segment_last;
	assign out_ch.error_code = res_q.error_code;

endmodule
`default_nettype wire

/* sv/hmf_checker.sv */
// Port-level checks of the framer and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"
module hmf_checker import hmf_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic [1:0] segment,
	input wire logic       segment_last,
	input wire logic [2:0] error_code
);

	logic err_seen_q;

	// Remembers that an error transaction was delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (out_valid && out_ready && error_code != ERR_NONE) begin
			err_seen_q <= 1'b1;
		end
	end

	`HMF_ASSERT_IMP(a_hold, clk, arst_n, out_valid && !out_ready, ##1 out_valid, "result dropped while stalled")
	`HMF_ASSERT_IMP(a_err_blank, clk, arst_n, out_valid && error_code != ERR_NONE, out_byte == 8'h00 && segment == SEG_HEADER && !segment_last, "error result carries payload")
	`HMF_ASSERT_IMP(a_code, clk, arst_n, out_valid, error_code <= ERR_MAX_CODE, "unknown error code")
	`HMF_ASSERT_IMP(a_sticky, clk, arst_n, out_valid && err_seen_q, error_code != ERR_NONE, "error not sticky")
	`HMF_ASSERT_IMP(a_accept, clk, arst_n, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind http1_message_framer_core hmf_checker u_hmf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_byte     (out_ch.out_byte),
	.segment      (out_ch.segment),
	.segment_last (out_ch.segment_last),
	.error_code   (out_ch.error_code)
);
`default_nettype wire
